>>> rtl/core/bcpm_pkg.sv
package bcpm_pkg;

  localparam int BUTTON_W = 4;
  localparam int MASK_W   = 16;
  localparam int CMD_W    = 8;
  localparam int POP_W    = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic                opcode;
    logic [BUTTON_W-1:0] button;
    logic [MASK_W-1:0]   modifiers;
    logic [CMD_W-1:0]    command;
  } req_t;

  typedef struct packed {
    logic [CMD_W-1:0] matched_command;
    logic             found;
    logic             status;
  } resp_t;

  // one binding as held in a cell
  typedef struct packed {
    logic [BUTTON_W-1:0] button;
    logic [MASK_W-1:0]   mask;
    logic [CMD_W-1:0]    cmd;
    logic [POP_W-1:0]    pop;
  } entry_t;

  // item travelling down the chain, one cell per cycle
  typedef struct packed {
    logic   live;
    logic   opcode;
    logic   ent_valid;
    logic   displace;
    logic   hit;
    entry_t ent;
  } token_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_WALK
  } state_t;

  function automatic logic [POP_W-1:0] popcount16(input logic [MASK_W-1:0] v);
    logic [POP_W-1:0] lo;
    logic [POP_W-1:0] hi;
    lo = '0;
    hi = '0;
    for (int i = 0; i < MASK_W / 2; i++) begin
      lo = lo + POP_W'(v[i]);
      hi = hi + POP_W'(v[i + MASK_W / 2]);
    end
    return lo + hi;
  endfunction

endpackage

>>> rtl/core/bcpm_cell.sv
module bcpm_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            occupied,
  input  bcpm_pkg::token_t tok_in,
  output bcpm_pkg::token_t tok_out
);
  import bcpm_pkg::*;

  entry_t held;
  token_t tok_next;
  logic   take;

  always_comb begin
    tok_next = tok_in;
    take     = 1'b0;
    if (tok_in.live) begin
      if (tok_in.opcode == OP_INSERT) begin
        // once placed, every later entry just shifts down one cell
        if (tok_in.ent_valid &&
            (tok_in.displace || !occupied || tok_in.ent.pop >= held.pop)) begin
          take               = 1'b1;
          tok_next.ent       = held;
          tok_next.ent_valid = occupied;
          tok_next.displace  = 1'b1;
        end
      end else begin
        if (!tok_in.hit && occupied && held.button == tok_in.ent.button &&
            (tok_in.ent.mask & held.mask) == held.mask) begin
          tok_next.hit     = 1'b1;
          tok_next.ent.cmd = held.cmd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held <= tok_in.ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.live <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

>>> rtl/core/button_combo_priority_matcher_unit.sv
// button combo priority matcher
//
// request channel: an item (opcode, button, modifiers, command) is taken at a
// rising edge with start high and busy low. opcode insert adds a binding for
// the trigger button, opcode lookup asks which binding fires for the held mask.
// response channel: done is high for exactly one cycle with the result on
// response; the receiver always takes it, there is no way to hold it off.
//
// all bindings sit in one row of MAX_ENTRIES cells, sorted by popcount of the
// mask, newest first among equal counts; per button this is the list order.
// an item walks the row one cell per clock, so every item takes the same time:
// done is registered from the token leaving the last cell, and busy drops in
// the done cycle; no new item is taken until the last one is done, and the row
// length sets the walk time.
//
// an insert into a full row, or for a button at or above NUM_BUTTONS, still
// walks the row but writes nothing; a full row answers status 1 to an insert of a valid button.
// reset empties the row (fill count to zero) and drops any item in flight;
// cell contents are don't-care until written.
module button_combo_priority_matcher_unit #(
  parameter int NUM_BUTTONS = 16,
  parameter int MAX_ENTRIES = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  bcpm_pkg::req_t  request,
  output logic            done,
  output bcpm_pkg::resp_t response
);
  import bcpm_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  state_t          state;
  state_t          state_next;
  logic            launch;
  logic            btn_ok;
  logic            full;
  logic [CNT_W-1:0] entry_count;
  logic            pend_inc;
  logic            pend_full;
  token_t          tok_launch_next;
  token_t          tok_launch;
  token_t          chain [MAX_ENTRIES+1];
  token_t          tok_end;
  resp_t           response_next;

  assign btn_ok  = (32'(request.button) < 32'(NUM_BUTTONS));
  assign full    = (entry_count == CNT_W'(MAX_ENTRIES));
  assign tok_end = chain[MAX_ENTRIES];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (tok_end.live) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // handshake outputs
  always_comb begin
    busy   = 1'b1;
    launch = 1'b0;
    case (state)
      ST_IDLE: begin
        busy   = 1'b0;
        launch = start;
      end
      ST_WALK: begin
        busy = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // token that enters the first cell
  always_comb begin
    tok_launch_next.live       = launch;
    tok_launch_next.opcode     = request.opcode;
    tok_launch_next.ent_valid  = (request.opcode == OP_INSERT) && btn_ok && !full;
    tok_launch_next.displace   = 1'b0;
    tok_launch_next.hit        = 1'b0;
    tok_launch_next.ent.button = request.button;
    tok_launch_next.ent.mask   = request.modifiers;
    tok_launch_next.ent.cmd    = request.command;
    tok_launch_next.ent.pop    = popcount16(request.modifiers);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_launch.live <= 1'b0;
    end else begin
      tok_launch <= tok_launch_next;
    end
  end

  assign chain[0] = tok_launch;

  // what the item does to the fill count and to its status, held until it leaves the row
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_inc  <= 1'b0;
      pend_full <= 1'b0;
    end else if (launch) begin
      pend_inc  <= tok_launch_next.ent_valid;
      pend_full <= (request.opcode == OP_INSERT) && btn_ok && full;
    end
  end

  // the row of cells; cell i holds a binding while i is below the fill count
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    bcpm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .occupied (CNT_W'(i) < entry_count),
      .tok_in   (chain[i]),
      .tok_out  (chain[i+1])
    );
  end

  // response from the token leaving the last cell
  always_comb begin
    response_next.found           = (tok_end.opcode == OP_LOOKUP) && tok_end.hit;
    response_next.matched_command = response_next.found ? tok_end.ent.cmd : '0;
    response_next.status          = pend_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= 1'b0;
      entry_count <= '0;
    end else begin
      done <= tok_end.live;
      if (tok_end.live && pend_inc) begin
        entry_count <= entry_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_end.live) begin
      response <= response_next;
    end
  end

  // checks
  a_done_after_walk: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_WALK))
    else $error("done without an item walking the row");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_ENTRIES))
    else $error("fill count beyond row length");

  a_launch_busy: assert property (@(posedge clk) disable iff (rst)
    chain[0].live |-> (state == ST_WALK))
    else $error("item entered the row while idle");

  a_refused_not_found: assert property (@(posedge clk) disable iff (rst)
    (done && response.status) |-> !response.found)
    else $error("refused insert reported a match");

  a_count_steady: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && !done) |=> $stable(entry_count) || $past(tok_end.live))
    else $error("fill count moved while no item was in flight");

endmodule

>>> test/button_combo_priority_matcher_unit_tb.sv
`timescale 1ns / 100ps

module button_combo_priority_matcher_unit_tb;
  import bcpm_pkg::*;

  localparam int NUM_BUTTONS = 16;
  localparam int MAX_ENTRIES = 64;
  // every item walks the whole row, so this covers any late or stray result
  localparam int TAIL_CYCLES = MAX_ENTRIES + 16;
  // about 700 items, each walking the whole row, plus the longest gaps, taken several times over
  localparam int CYCLE_LIMIT = 400000;

  // one item waiting to go out, with its lead-in gap and an optional drain
  typedef struct {
    req_t req;
    int   hold;
    bit   drain;
  } queued_item_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  req_t  request = '0;
  logic  busy;
  logic  done;
  resp_t response;

  queued_item_t pending[$];
  resp_t        due_responses[$];
  int           mismatches = 0;
  int           cycle_count = 0;

  // shadow of the binding store: heads and links hold slot + 1, 0 ends a list
  int          head_of[NUM_BUTTONS];
  logic [15:0] slot_mask[MAX_ENTRIES];
  logic [7:0]  slot_cmd[MAX_ENTRIES];
  int          slot_next[MAX_ENTRIES];
  int          used_slots = 0;

  // (mask, button) pairs of every queued insert, used to aim lookups at real bindings
  logic [19:0] bound_pairs[$];

  button_combo_priority_matcher_unit #(
    .NUM_BUTTONS(NUM_BUTTONS),
    .MAX_ENTRIES(MAX_ENTRIES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .response(response)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(input string what);
    $display("error at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // apply one accepted item to the shadow store and queue the answer it must give
  task automatic resolve_binding(input req_t r);
    resp_t ans;
    int    cur;
    int    prv;
    int    slot;
    ans = '0;
    if (r.opcode == OP_INSERT) begin
      if (r.button < NUM_BUTTONS) begin
        if (used_slots >= MAX_ENTRIES) begin
          // store full: nothing changes, insert refused
          ans.status = 1'b1;
        end else begin
          slot = used_slots;
          prv = -1;
          cur = head_of[r.button] - 1;
          // skip entries with strictly more set bits, so equal counts go newest first
          while (cur >= 0 && $countones(r.modifiers) < $countones(slot_mask[cur])) begin
            prv = cur;
            cur = slot_next[cur] - 1;
          end
          slot_mask[slot] = r.modifiers;
          slot_cmd[slot] = r.command;
          if (prv < 0) begin
            slot_next[slot] = head_of[r.button];
            head_of[r.button] = slot + 1;
          end else begin
            slot_next[slot] = slot_next[prv];
            slot_next[prv] = slot + 1;
          end
          used_slots++;
        end
      end
    end else if (r.button < NUM_BUTTONS) begin
      // first entry whose mask is a subset of the held buttons wins
      cur = head_of[r.button] - 1;
      while (cur >= 0 && !ans.found) begin
        if ((r.modifiers & slot_mask[cur]) == slot_mask[cur]) begin
          ans.matched_command = slot_cmd[cur];
          ans.found = 1'b1;
        end
        cur = slot_next[cur] - 1;
      end
    end
    due_responses.push_back(ans);
  endtask

  task automatic push_item(input logic op, input logic [3:0] b, input logic [15:0] m,
                           input logic [7:0] c, input int hold, input bit drain);
    queued_item_t it;
    it.req.opcode = op;
    it.req.button = b;
    it.req.modifiers = m;
    it.req.command = c;
    it.hold = hold;
    it.drain = drain;
    pending.push_back(it);
    if (op == OP_INSERT) bound_pairs.push_back({b, m});
  endtask

  // stimulus: directed items first, then random ones
  initial begin : build_items
    int          n;
    int          pick;
    int          calm;
    int          hold;
    bit          drain;
    logic [3:0]  b;
    logic [15:0] m;
    logic [19:0] pair;
    for (n = 0; n < NUM_BUTTONS; n++) head_of[n] = 0;

    // empty list answers not found
    push_item(OP_LOOKUP, 4'd0, 16'hFFFF, 8'h00, 0, 1'b0);
    // empty mask, then two masks of equal count, the full mask and a single bit
    push_item(OP_INSERT, 4'd0, 16'h0000, 8'h01, 0, 1'b0);
    push_item(OP_INSERT, 4'd0, 16'h0003, 8'h02, 0, 1'b0);
    push_item(OP_INSERT, 4'd0, 16'h0005, 8'h03, 2, 1'b0);
    push_item(OP_INSERT, 4'd0, 16'hFFFF, 8'hFF, 0, 1'b0);
    push_item(OP_INSERT, 4'd0, 16'h0100, 8'h80, 0, 1'b0);
    // full mask first, newer equal count ahead, subset checks, empty mask catches all
    push_item(OP_LOOKUP, 4'd0, 16'hFFFF, 8'h00, 0, 1'b0);
    push_item(OP_LOOKUP, 4'd0, 16'h0007, 8'hFF, 0, 1'b0);
    push_item(OP_LOOKUP, 4'd0, 16'h0003, 8'h00, 1, 1'b0);
    push_item(OP_LOOKUP, 4'd0, 16'h0000, 8'h00, 0, 1'b0);
    push_item(OP_LOOKUP, 4'd0, 16'h0100, 8'h00, 0, 1'b0);
    // top button index, top mask bit
    push_item(OP_INSERT, 4'd15, 16'h8000, 8'h7F, 0, 1'b0);
    push_item(OP_LOOKUP, 4'd15, 16'h7FFF, 8'h00, 0, 1'b0);
    push_item(OP_LOOKUP, 4'd15, 16'h8000, 8'h00, 0, 1'b0);
    push_item(OP_LOOKUP, 4'd7, 16'h1234, 8'h00, 0, 1'b0);
    push_item(OP_INSERT, 4'd15, 16'hAAAA, 8'h55, 0, 1'b0);
    // command on a lookup is ignored
    push_item(OP_LOOKUP, 4'd15, 16'hFFFF, 8'hAA, 0, 1'b0);

    calm = 0;
    for (n = 0; n < 650; n++) begin
      // sender gap: mostly short, a few long, with stretches of back-to-back items
      if (calm > 0) begin
        hold = 0;
        calm--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          calm = $urandom_range(10, 30);
          hold = 0;
        end else if (pick < 45) hold = 0;
        else if (pick < 80) hold = $urandom_range(1, 4);
        else if (pick < 93) hold = $urandom_range(5, 40);
        else hold = $urandom_range(60, 120);
      end
      // hold off until every pending answer is in
      drain = (n == 120 || n == 420);
      // favor a few buttons so their lists grow long
      b = ($urandom_range(0, 9) < 6) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
      if ($urandom_range(0, 4) == 0) begin
        // inserts fill the store around mid-run, later ones are refused
        pick = $urandom_range(0, 3);
        case (pick)
          0: m = 16'($urandom);
          1: m = 16'($urandom & $urandom & $urandom);
          2: m = 16'h1 << $urandom_range(0, 15);
          default: begin
            // repeat an existing mask for equal-count ordering
            if (bound_pairs.size() != 0)
              m = bound_pairs[$urandom_range(0, bound_pairs.size() - 1)][15:0];
            else m = '0;
          end
        endcase
        push_item(OP_INSERT, b, m, 8'($urandom), hold, drain);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70 && bound_pairs.size() != 0) begin
          // aim at a real binding, held mask a superset of it
          pair = bound_pairs[$urandom_range(0, bound_pairs.size() - 1)];
          b = pair[19:16];
          m = pair[15:0] | 16'($urandom & $urandom);
          // sometimes drop one bit so it just misses
          if (pick < 15) m = m & ~(16'h1 << $urandom_range(0, 15));
        end else if (pick < 85) begin
          m = 16'($urandom);
        end else begin
          m = 16'($urandom & $urandom);
        end
        push_item(OP_LOOKUP, b, m, 8'($urandom), hold, drain);
      end
    end
  end

  // driver: present the next item once the previous one is taken and its gap is over
  always @(posedge clk) begin : drive_items
    queued_item_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      // item taken at this edge
      if (start) resolve_binding(request);
      if (pending.size() != 0 && pending[0].hold != 0) begin
        pending[0].hold = pending[0].hold - 1;
        start <= 1'b0;
      end else if (pending.size() != 0 && !(pending[0].drain && due_responses.size() != 0)) begin
        nxt = pending.pop_front();
        request <= nxt.req;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: each done cycle carries one result, checked against the oldest answer
  always @(posedge clk) begin : check_results
    resp_t want;
    if (!rst && done) begin
      if (due_responses.size() == 0) begin
        report($sformatf("result with no item outstanding (cmd %02h found %0b status %0b)",
                         response.matched_command, response.found, response.status));
      end else begin
        want = due_responses.pop_front();
        if (response.matched_command !== want.matched_command)
          report($sformatf("matched_command %02h, wanted %02h",
                           response.matched_command, want.matched_command));
        if (response.found !== want.found)
          report($sformatf("found %0b, wanted %0b", response.found, want.found));
        if (response.status !== want.status)
          report($sformatf("status %0b, wanted %0b", response.status, want.status));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("button_combo_priority_matcher_unit: mismatch");
      $finish;
    end
  end

  initial begin : run_control
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // all items taken and all answers in
    do @(posedge clk);
    while (pending.size() != 0 || start || due_responses.size() != 0);
    // let any stray result show up
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("button_combo_priority_matcher_unit: match");
    else $display("button_combo_priority_matcher_unit: mismatch");
    $finish;
  end

endmodule

>>> files.f
rtl/core/bcpm_pkg.sv
rtl/core/bcpm_cell.sv
rtl/core/button_combo_priority_matcher_unit.sv
test/button_combo_priority_matcher_unit_tb.sv
